// ----- src/ultank_pkg.sv -----
// ----------------------------------------------------------------------------
// ultank_pkg
// Shared types and constants of the ultrasonic tank level gauge.
// ----------------------------------------------------------------------------
`default_nettype none

package ultank_pkg;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_EMPTY_DEPTH = 2'd0,
		REG_FULL_DEPTH  = 2'd1,
		REG_LOW_MARK    = 2'd2,
		REG_HIGH_MARK   = 2'd3
	} ultank_reg_t;

	localparam int EchoW    = 15;
	localparam int DepthW   = 9;
	localparam int PctW     = 7;
	localparam int DistW    = 16;
	localparam int CfgW     = 9;
	localparam int AddrW    = 2;

	localparam int MissLimit = 3;
	localparam int MissW     = $clog2(MissLimit + 1);

	localparam logic [DepthW-1:0] EmptyReset = 9'd200;
	localparam logic [DepthW-1:0] FullReset  = 9'd20;
	localparam logic [PctW-1:0]   LowReset   = 7'd20;
	localparam logic [PctW-1:0]   HighReset  = 7'd90;
	localparam logic [PctW-1:0]   PctFull    = 7'd100;

	// distance = round(echo * 0.01715 cm) in 1/100 cm = (echo*343 + 100) / 200
	// the divide by 200 is a multiply by ceil(2^31 / 200) and a shift by 31,
	// exact for every numerator below 2^31 / 152
	localparam int DistMul   = 343;
	localparam int DistRound = 100;
	localparam int DistXW    = 24;
	localparam int DistRecip = 10737419;
	localparam int DistShift = 31;
	localparam int ProdW     = 48;

	// shift-subtract divider for the level percent
	localparam int DivW      = 24;
	localparam int DivCntW   = 4;
	localparam int LvlSteps  = 7;

	// level arithmetic
	localparam int NumW = 18;
	localparam int DenW = 10;

	typedef struct packed {
		logic capture;
		logic timeout;
		logic dist_start;
		logic dist_store;
		logic prep;
		logic lvl_check;
		logic lvl_store;
		logic out_load;
	} ultank_cmd_t;

	typedef struct packed {
		logic echo_zero;
		logic div_done;
		logic lvl_direct;
		logic out_free;
	} ultank_sts_t;

endpackage

`default_nettype wire

// ----- src/ultank_div.sv -----
// ----------------------------------------------------------------------------
// ultank_div
// Shift-subtract divider, one quotient bit per cycle, divisor preshifted.
// ----------------------------------------------------------------------------
`default_nettype none

module ultank_div (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	input  wire logic [ultank_pkg::DivW-1:0]           dividend,
	input  wire logic [ultank_pkg::DivW-1:0]           divisor_sh,
	input  wire logic [ultank_pkg::DivCntW-1:0]        last_step,
	output logic                                       done,
	output logic [ultank_pkg::PctW-1:0]                quotient
);

	logic                                busy_q;
	logic                                done_q;
	logic [ultank_pkg::DivCntW-1:0]      cnt_q;
	logic [ultank_pkg::DivW-1:0]         rem_q;
	logic [ultank_pkg::DivW-1:0]         ds_q;
	logic [ultank_pkg::PctW-1:0]         quo_q;
	logic                                fits;

	assign fits = rem_q >= ds_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= last_step;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			ds_q  <= divisor_sh;
			quo_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - ds_q;
			end
			ds_q  <= ds_q >> 1;
			quo_q <= {quo_q[ultank_pkg::PctW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ----- src/ultank_dp.sv -----
// ----------------------------------------------------------------------------
// ultank_dp
// Datapath: configuration, gauge state, distance and level arithmetic, output.
// ----------------------------------------------------------------------------
`default_nettype none

module ultank_dp (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire ultank_pkg::ultank_cmd_t            cmd,
	output ultank_pkg::ultank_sts_t                 sts,
	input  wire logic [ultank_pkg::EchoW-1:0]       echo_width_us,
	input  wire logic                               cfg_we,
	input  wire logic [ultank_pkg::AddrW-1:0]       cfg_addr,
	input  wire logic [ultank_pkg::CfgW-1:0]        cfg_wdata,
	input  wire logic                               out_ready,
	output logic                                    out_valid,
	output logic [ultank_pkg::DistW-1:0]            distance_centi_cm,
	output logic [ultank_pkg::PctW-1:0]             level_pct,
	output logic                                    valid_reading,
	output logic                                    fault,
	output logic                                    tank_low,
	output logic                                    tank_high
);

	logic [ultank_pkg::DepthW-1:0]       empty_q;
	logic [ultank_pkg::DepthW-1:0]       full_q;
	logic [ultank_pkg::PctW-1:0]         low_mark_q;
	logic [ultank_pkg::PctW-1:0]         high_mark_q;

	logic [ultank_pkg::EchoW-1:0]        echo_q;
	logic [ultank_pkg::DistXW-1:0]       dist_x_q;
	logic [ultank_pkg::DistW-1:0]        dist_q;
	logic [ultank_pkg::PctW-1:0]         level_q;
	logic                                rdy_q;
	logic                                err_q;
	logic [ultank_pkg::MissW-1:0]        miss_q;

	logic signed [ultank_pkg::NumW-1:0]  num_q;
	logic signed [ultank_pkg::NumW-1:0]  den100_q;
	logic [ultank_pkg::DenW-1:0]         den_q;
	logic                                bad_q;

	logic                                out_valid_q;
	logic [ultank_pkg::DistW-1:0]        out_dist_q;
	logic [ultank_pkg::PctW-1:0]         out_level_q;
	logic                                out_vr_q;
	logic                                out_fault_q;
	logic                                out_low_q;
	logic                                out_high_q;

	logic [ultank_pkg::MissW-1:0]        miss_next;
	logic [ultank_pkg::DistXW-1:0]       dist_dividend;
	logic [ultank_pkg::ProdW-1:0]        dist_prod;
	logic [ultank_pkg::DivW-1:0]         lvl_dividend;
	logic [ultank_pkg::DivW-1:0]         div_divisor;
	logic                                div_start;
	logic                                div_done;
	logic [ultank_pkg::PctW-1:0]         div_quo;
	logic [ultank_pkg::DistW-1:0]        empty100;
	logic signed [ultank_pkg::NumW-1:0]  num_s;
	logic signed [ultank_pkg::DenW-1:0]  den_s;
	logic signed [ultank_pkg::NumW-1:0]  den100_s;
	logic                                num_nonpos;
	logic                                num_over;
	logic                                lvl_direct;
	logic                                vr_now;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_q     <= ultank_pkg::EmptyReset;
			full_q      <= ultank_pkg::FullReset;
			low_mark_q  <= ultank_pkg::LowReset;
			high_mark_q <= ultank_pkg::HighReset;
		end else if (cfg_we) begin
			unique case (ultank_pkg::ultank_reg_t'(cfg_addr))
				ultank_pkg::REG_EMPTY_DEPTH: empty_q     <= cfg_wdata[ultank_pkg::DepthW-1:0];
				ultank_pkg::REG_FULL_DEPTH:  full_q      <= cfg_wdata[ultank_pkg::DepthW-1:0];
				ultank_pkg::REG_LOW_MARK:    low_mark_q  <= cfg_wdata[ultank_pkg::PctW-1:0];
				ultank_pkg::REG_HIGH_MARK:   high_mark_q <= cfg_wdata[ultank_pkg::PctW-1:0];
				default: ;
			endcase
		end
	end

	// timeout counter saturates at the limit
	assign miss_next = (miss_q < ultank_pkg::MissW'(ultank_pkg::MissLimit))
		? miss_q + 1'b1 : miss_q;

	assign dist_dividend = ultank_pkg::DistXW'(echo_q) * ultank_pkg::DistXW'(ultank_pkg::DistMul)
		+ ultank_pkg::DistXW'(ultank_pkg::DistRound);
	assign dist_prod     = ultank_pkg::ProdW'(dist_x_q)
		* ultank_pkg::ProdW'(ultank_pkg::DistRecip);
	assign lvl_dividend  = (ultank_pkg::DivW'(num_q[ultank_pkg::NumW-2:0]) << 1)
		+ ultank_pkg::DivW'(den_q);

	assign empty100 = ultank_pkg::DistW'(empty_q) * ultank_pkg::DistW'(100);
	assign num_s    = $signed({2'b00, empty100}) - $signed({2'b00, dist_q});
	assign den_s    = $signed({1'b0, empty_q}) - $signed({1'b0, full_q});
	assign den100_s = $signed({{(ultank_pkg::NumW-ultank_pkg::DenW){den_s[ultank_pkg::DenW-1]}},
		den_s}) * $signed(ultank_pkg::NumW'(100));

	assign num_nonpos = num_q[ultank_pkg::NumW-1] || (num_q == '0);
	assign num_over   = num_q >= den100_q;
	assign lvl_direct = bad_q || num_nonpos || num_over;

	assign div_start   = cmd.lvl_check && !lvl_direct;
	assign div_divisor = ultank_pkg::DivW'(den_q) << ultank_pkg::LvlSteps;

	ultank_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (div_start),
		.dividend   (lvl_dividend),
		.divisor_sh (div_divisor),
		.last_step  (ultank_pkg::DivCntW'(ultank_pkg::LvlSteps - 1)),
		.done       (div_done),
		.quotient   (div_quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			echo_q <= echo_width_us;
		end
		if (cmd.dist_start) begin
			dist_x_q <= dist_dividend;
		end
		if (cmd.prep) begin
			num_q    <= num_s;
			den_q    <= den_s;
			den100_q <= den100_s;
			bad_q    <= empty_q <= ({1'b0, full_q} + 1'b1);
		end
	end

	// gauge state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q  <= '0;
			level_q <= '0;
			rdy_q   <= 1'b0;
			err_q   <= 1'b0;
			miss_q  <= '0;
		end else begin
			if (cmd.timeout) begin
				miss_q <= miss_next;
				if (miss_next >= ultank_pkg::MissW'(ultank_pkg::MissLimit)) begin
					err_q <= 1'b1;
					rdy_q <= 1'b0;
				end
			end
			if (cmd.dist_start) begin
				miss_q <= '0;
				rdy_q  <= 1'b1;
			end
			if (cmd.dist_store) begin
				dist_q <= dist_prod[ultank_pkg::DistShift +: ultank_pkg::DistW];
			end
			if (cmd.lvl_check) begin
				err_q <= bad_q;
				if (lvl_direct) begin
					level_q <= (bad_q || num_nonpos) ? '0 : ultank_pkg::PctFull;
				end
			end
			if (cmd.lvl_store) begin
				level_q <= div_quo;
			end
		end
	end

	assign vr_now = rdy_q && !err_q;

	// output register, held while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_dist_q  <= dist_q;
			out_level_q <= level_q;
			out_vr_q    <= vr_now;
			out_fault_q <= err_q;
			out_low_q   <= vr_now && (level_q <= low_mark_q);
			out_high_q  <= vr_now && (level_q >= high_mark_q);
		end
	end

	assign sts.echo_zero  = echo_q == '0;
	assign sts.div_done   = div_done;
	assign sts.lvl_direct = lvl_direct;
	assign sts.out_free   = !out_valid_q || out_ready;

	assign out_valid         = out_valid_q;
	assign distance_centi_cm = out_dist_q;
	assign level_pct         = out_level_q;
	assign valid_reading     = out_vr_q;
	assign fault             = out_fault_q;
	assign tank_low          = out_low_q;
	assign tank_high         = out_high_q;

endmodule

`default_nettype wire

// ----- src/ultank_ctrl.sv -----
// ----------------------------------------------------------------------------
// ultank_ctrl
// Sequencer: steps one item through distance, level and output load.
// ----------------------------------------------------------------------------
`default_nettype none

module ultank_ctrl (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire ultank_pkg::ultank_sts_t  sts,
	output ultank_pkg::ultank_cmd_t       cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIST,
		ST_PREP,
		ST_CHECK,
		ST_LVL_WAIT,
		ST_FINISH
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE:      if (in_valid) state_q <= ST_LOAD;
				ST_LOAD:      state_q <= sts.echo_zero ? ST_FINISH : ST_DIST;
				ST_DIST:      state_q <= ST_PREP;
				ST_PREP:      state_q <= ST_CHECK;
				ST_CHECK:     state_q <= sts.lvl_direct ? ST_FINISH : ST_LVL_WAIT;
				ST_LVL_WAIT:  if (sts.div_done) state_q <= ST_FINISH;
				ST_FINISH:    if (sts.out_free) state_q <= ST_IDLE;
				default:      state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready = state_q == ST_IDLE;

	always_comb begin
		cmd            = '0;
		cmd.capture    = (state_q == ST_IDLE) && in_valid;
		cmd.timeout    = (state_q == ST_LOAD) && sts.echo_zero;
		cmd.dist_start = (state_q == ST_LOAD) && !sts.echo_zero;
		cmd.dist_store = state_q == ST_DIST;
		cmd.prep       = state_q == ST_PREP;
		cmd.lvl_check  = state_q == ST_CHECK;
		cmd.lvl_store  = (state_q == ST_LVL_WAIT) && sts.div_done;
		cmd.out_load   = (state_q == ST_FINISH) && sts.out_free;
	end

endmodule

`default_nettype wire

// ----- src/ultrasonic_tank_level.sv -----
// ----------------------------------------------------------------------------
// ultrasonic_tank_level
// Converts echo widths into distance, fill level and tank status flags.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one echo width in us per item;
//   zero marks a timeout. Every input item yields exactly one output item on
//   out_valid/out_ready with distance, level and status flags.
//   cfg_we/cfg_addr/cfg_wdata write empty depth, full depth, low and high
//   marks; write them only while no item is in flight.
//   A timeout goes from ST_LOAD straight to ST_FINISH. A good echo passes
//   ST_LOAD, ST_DIST, ST_PREP, ST_CHECK and ST_LVL_WAIT to ST_FINISH, and skips
//   ST_LVL_WAIT when the level clamps or calibration is bad. The distance is a
//   registered reciprocal multiply; the level percent comes from a shift-
//   subtract divider, 7 steps and then a registered done flag. One item is
//   worked at a time, so a new item is taken in the cycle after the previous
//   result is loaded.
//   The result sits in an output register; while the receiver stalls the
//   next item is accepted and computed, then waits to be loaded.
//   Reset restores the register defaults (200, 20, 20, 90 cm/%) and clears
//   distance, level, flags and the timeout count.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_tank_level (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [ultank_pkg::EchoW-1:0]      echo_width_us,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [ultank_pkg::DistW-1:0]           distance_centi_cm,
	output logic [ultank_pkg::PctW-1:0]            level_pct,
	output logic                                   valid_reading,
	output logic                                   fault,
	output logic                                   tank_low,
	output logic                                   tank_high,
	input  wire logic                              cfg_we,
	input  wire logic [ultank_pkg::AddrW-1:0]      cfg_addr,
	input  wire logic [ultank_pkg::CfgW-1:0]       cfg_wdata
);

	ultank_pkg::ultank_cmd_t cmd;
	ultank_pkg::ultank_sts_t sts;

	ultank_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ultank_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.echo_width_us     (echo_width_us),
		.cfg_we            (cfg_we),
		.cfg_addr          (cfg_addr),
		.cfg_wdata         (cfg_wdata),
		.out_ready         (out_ready),
		.out_valid         (out_valid),
		.distance_centi_cm (distance_centi_cm),
		.level_pct         (level_pct),
		.valid_reading     (valid_reading),
		.fault             (fault),
		.tank_low          (tank_low),
		.tank_high         (tank_high)
	);

	a_fault_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(fault && valid_reading))
		else $error("fault and valid_reading both set");

	a_flags_need_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (tank_low || tank_high)) |-> valid_reading)
		else $error("tank flag without a valid reading");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (level_pct <= ultank_pkg::PctFull))
		else $error("level above 100 percent");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while an item is in flight");

endmodule

`default_nettype wire
